### rtl/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg: shared types and constants for camera point projection pairing
// Fixed field widths, sequencer codes, command/status structs, micro-op ROM.
// ----------------------------------------------------------------------------
package cpp_pkg;

    localparam int COORD_W   = 32;
    localparam int LABEL_W   = 16;
    localparam int PIXOUT_W  = 16;
    localparam int FRAC      = 28;
    localparam int DIV_STEPS = 31;
    localparam int MUL_STEPS = 5;
    localparam int NUM_UOPS  = 32;
    localparam int OPND_N    = 22;

    localparam logic signed [63:0] LIMIT = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_DIV, S_OP, S_MUL, S_WB, S_PIX, S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_TX, OP_TY, OP_TXX, OP_TYY, OP_TXY, OP_R2, OP_R4, OP_R6,
        OP_DIST, OP_XD, OP_YD, OP_T0, OP_K1, OP_K2, OP_K3, OP_P1,
        OP_P2, OP_FX, OP_FY, OP_CX, OP_CY, OP_ONE
    } t_opnd;

    typedef enum logic {UOP_ADD, UOP_MUL} t_kind;

    typedef struct packed {
        t_kind kind;
        t_opnd a;
        t_opnd b;
        logic  sh16;
        t_opnd dst;
    } t_uop;

    typedef struct packed {
        logic [63:0] depth;
        logic [63:0] focal;
        logic [63:0] pp;
        logic [31:0] img;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
        logic [63:0] tan;
    } t_cfg;

    typedef struct packed {
        logic       load;
        logic       div_init;
        logic       div_step;
        logic       op_issue;
        logic       mul_step;
        logic       mul_wb;
        logic       pend_load;
        logic       emit;
        logic [4:0] cnt;
        t_uop       uop;
    } t_cmd;

    typedef struct packed {
        logic chk_ok;
        logic pix_ok;
        logic top;
        logic pending;
    } t_sts;

    function automatic t_uop mk(input t_kind k, input t_opnd a, input t_opnd b,
                                input logic sh, input t_opnd d);
        t_uop u;
        u.kind = k;
        u.a    = a;
        u.b    = b;
        u.sh16 = sh;
        u.dst  = d;
        return u;
    endfunction

    // Distortion polynomial, focal scaling and principal point offset, one operation per entry
    function automatic t_uop uop_rom(input logic [4:0] pc);
        t_uop u;
        case (pc)
            5'd0:  u = mk(UOP_MUL, OP_TX,   OP_TX,   1'b0, OP_TXX);
            5'd1:  u = mk(UOP_MUL, OP_TY,   OP_TY,   1'b0, OP_TYY);
            5'd2:  u = mk(UOP_MUL, OP_TX,   OP_TY,   1'b0, OP_TXY);
            5'd3:  u = mk(UOP_ADD, OP_TXX,  OP_TYY,  1'b0, OP_R2);
            5'd4:  u = mk(UOP_MUL, OP_R2,   OP_R2,   1'b0, OP_R4);
            5'd5:  u = mk(UOP_MUL, OP_R4,   OP_R2,   1'b0, OP_R6);
            5'd6:  u = mk(UOP_MUL, OP_K1,   OP_R2,   1'b0, OP_T0);
            5'd7:  u = mk(UOP_ADD, OP_ONE,  OP_T0,   1'b0, OP_DIST);
            5'd8:  u = mk(UOP_MUL, OP_K2,   OP_R4,   1'b0, OP_T0);
            5'd9:  u = mk(UOP_ADD, OP_DIST, OP_T0,   1'b0, OP_DIST);
            5'd10: u = mk(UOP_MUL, OP_K3,   OP_R6,   1'b0, OP_T0);
            5'd11: u = mk(UOP_ADD, OP_DIST, OP_T0,   1'b0, OP_DIST);
            5'd12: u = mk(UOP_MUL, OP_P1,   OP_TXY,  1'b0, OP_XD);
            5'd13: u = mk(UOP_ADD, OP_XD,   OP_XD,   1'b0, OP_XD);
            5'd14: u = mk(UOP_MUL, OP_TX,   OP_DIST, 1'b0, OP_T0);
            5'd15: u = mk(UOP_ADD, OP_T0,   OP_XD,   1'b0, OP_XD);
            5'd16: u = mk(UOP_ADD, OP_TXX,  OP_TXX,  1'b0, OP_T0);
            5'd17: u = mk(UOP_ADD, OP_R2,   OP_T0,   1'b0, OP_T0);
            5'd18: u = mk(UOP_MUL, OP_P2,   OP_T0,   1'b0, OP_T0);
            5'd19: u = mk(UOP_ADD, OP_XD,   OP_T0,   1'b0, OP_XD);
            5'd20: u = mk(UOP_MUL, OP_P2,   OP_TXY,  1'b0, OP_YD);
            5'd21: u = mk(UOP_ADD, OP_YD,   OP_YD,   1'b0, OP_YD);
            5'd22: u = mk(UOP_MUL, OP_TY,   OP_DIST, 1'b0, OP_T0);
            5'd23: u = mk(UOP_ADD, OP_T0,   OP_YD,   1'b0, OP_YD);
            5'd24: u = mk(UOP_ADD, OP_TYY,  OP_TYY,  1'b0, OP_T0);
            5'd25: u = mk(UOP_ADD, OP_R2,   OP_T0,   1'b0, OP_T0);
            5'd26: u = mk(UOP_MUL, OP_P1,   OP_T0,   1'b0, OP_T0);
            5'd27: u = mk(UOP_ADD, OP_YD,   OP_T0,   1'b0, OP_YD);
            5'd28: u = mk(UOP_MUL, OP_XD,   OP_FX,   1'b1, OP_T0);
            5'd29: u = mk(UOP_ADD, OP_T0,   OP_CX,   1'b0, OP_XD);
            5'd30: u = mk(UOP_MUL, OP_YD,   OP_FY,   1'b1, OP_T0);
            default: u = mk(UOP_ADD, OP_T0, OP_CY,   1'b0, OP_YD);
        endcase
        return u;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(LIMIT)) begin
            return LIMIT;
        end else if (s < -65'(LIMIT)) begin
            return -LIMIT;
        end
        return s[63:0];
    endfunction

endpackage

### rtl/cpp_point_if.sv
// ----------------------------------------------------------------------------
// cpp_point_if: input point channel
// Valid/ready channel carrying one camera-frame point.
// ----------------------------------------------------------------------------
interface cpp_point_if import cpp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      is_top;
    logic [LABEL_W-1:0]        label;

    modport source (output valid, point_x, point_y, point_z, is_top, label,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_z, is_top, label,
                    output ready);
endinterface

### rtl/cpp_pair_if.sv
// ----------------------------------------------------------------------------
// cpp_pair_if: output pixel pair channel
// Valid/ready channel carrying one bottom/top pixel pair.
// ----------------------------------------------------------------------------
interface cpp_pair_if import cpp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LABEL_W-1:0]  pair_label;
    logic [PIXOUT_W-1:0] bottom_u;
    logic [PIXOUT_W-1:0] bottom_v;
    logic [PIXOUT_W-1:0] top_u;
    logic [PIXOUT_W-1:0] top_v;

    modport source (output valid, pair_label, bottom_u, bottom_v, top_u, top_v,
                    input ready);
    modport sink   (input valid, pair_label, bottom_u, bottom_v, top_u, top_v,
                    output ready);
endinterface

### rtl/cpp_ctrl.sv
// ----------------------------------------------------------------------------
// cpp_ctrl: sequencer for point projection
// Steps through depth check, division, micro-op program and pixel decision.
// ----------------------------------------------------------------------------
module cpp_ctrl import cpp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [4:0] r_pc, n_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pc    <= n_pc;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pc        = r_pc;
        o_cmd       = '0;
        o_cmd.cnt   = r_cnt;
        o_cmd.uop   = uop_rom(r_pc);
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.chk_ok) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    n_pc    = '0;
                    n_state = S_OP;
                end
            end
            S_OP: begin
                o_cmd.op_issue = 1'b1;
                if (o_cmd.uop.kind == UOP_MUL) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end else if (r_pc == 5'(NUM_UOPS - 1)) begin
                    n_state = S_PIX;
                end else begin
                    n_pc = r_pc + 5'd1;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 5'd1;
                if (r_cnt == 5'(MUL_STEPS - 1)) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_cmd.mul_wb = 1'b1;
                if (r_pc == 5'(NUM_UOPS - 1)) begin
                    n_state = S_PIX;
                end else begin
                    n_pc    = r_pc + 5'd1;
                    n_state = S_OP;
                end
            end
            S_PIX: begin
                n_state = S_IDLE;
                if (i_sts.pix_ok && !i_sts.top) begin
                    o_cmd.pend_load = 1'b1;
                end else if (i_sts.pix_ok && i_sts.pending) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/cpp_dpath.sv
// ----------------------------------------------------------------------------
// cpp_dpath: projection datapath
// Dual restoring divider, shared 32x32 multiplier with saturation, value
// registers, pixel bounds check and pending bottom pixel.
// ----------------------------------------------------------------------------
module cpp_dpath import cpp_pkg::*; #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  t_cfg                      i_cfg,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    input  logic signed [COORD_W-1:0] i_z,
    input  logic                      i_top,
    input  logic [LABEL_W-1:0]        i_label,
    output t_sts                      o_sts,
    output logic [LABEL_W-1:0]        o_label,
    output logic [PIXOUT_W-1:0]       o_bu,
    output logic [PIXOUT_W-1:0]       o_bv,
    output logic [PIXOUT_W-1:0]       o_tu,
    output logic [PIXOUT_W-1:0]       o_tv
);

    localparam logic [16:0] DIM_CAP = 17'(1) << PIXEL_BITS;

    // captured point
    logic signed [COORD_W-1:0] r_x, r_y, r_z;
    logic                      r_top;
    logic [LABEL_W-1:0]        r_label;

    // divider
    logic [31:0] r_ux, r_uy;
    logic [30:0] r_ud;
    logic        r_sx, r_sy;
    logic [30:0] r_rx, r_ry, r_qx, r_qy;

    // value registers
    logic signed [63:0] r_txx, r_tyy, r_txy, r_r2, r_r4, r_r6;
    logic signed [63:0] r_dist, r_xd, r_yd, r_t0;

    // multiplier
    logic [63:0]  r_ua, r_ub;
    logic         r_neg, r_sh16;
    t_opnd        r_dst;
    logic [63:0]  r_prod;
    logic [1:0]   r_pshf;
    logic [127:0] r_acc;

    // pending bottom and output
    logic                  r_pending;
    logic [PIXEL_BITS-1:0] r_pu, r_pv;
    logic [PIXOUT_W-1:0]   r_obu, r_obv, r_otu, r_otv;
    logic [LABEL_W-1:0]    r_olabel;

    logic [31:0] ux, uy;
    logic [33:0] wide_lim;
    logic        zpos;
    logic        chk_ok;

    always_comb begin
        ux       = r_x[31] ? 32'(-r_x) : 32'(r_x);
        uy       = r_y[31] ? 32'(-r_y) : 32'(r_y);
        zpos     = !r_z[31] && (r_z != '0);
        wide_lim = {1'b0, r_z[31:0], 1'b0} << 2;
        chk_ok   = zpos && (32'(r_z) >= i_cfg.depth[31:0])
                   && (32'(r_z) <= i_cfg.depth[63:32])
                   && (34'(ux) < wide_lim) && (34'(uy) < wide_lim);
    end

    assign o_sts.chk_ok = chk_ok;

    // one quotient bit per cycle for each axis: the three low dividend bits
    // give the integer part, then zeros give the fraction
    logic        nbx, nby;
    logic [31:0] tx_t, ty_t;
    always_comb begin
        nbx  = 1'b0;
        nby  = 1'b0;
        if (i_cmd.cnt <= 5'd2) begin
            nbx = r_ux[5'd2 - i_cmd.cnt];
            nby = r_uy[5'd2 - i_cmd.cnt];
        end
        tx_t = {r_rx, nbx};
        ty_t = {r_ry, nby};
    end

    logic signed [63:0] tx, ty;
    assign tx = r_sx ? -$signed({33'b0, r_qx}) : $signed({33'b0, r_qx});
    assign ty = r_sy ? -$signed({33'b0, r_qy}) : $signed({33'b0, r_qy});

    logic signed [63:0] opv [OPND_N];
    always_comb begin
        opv[OP_TX]   = tx;
        opv[OP_TY]   = ty;
        opv[OP_TXX]  = r_txx;
        opv[OP_TYY]  = r_tyy;
        opv[OP_TXY]  = r_txy;
        opv[OP_R2]   = r_r2;
        opv[OP_R4]   = r_r4;
        opv[OP_R6]   = r_r6;
        opv[OP_DIST] = r_dist;
        opv[OP_XD]   = r_xd;
        opv[OP_YD]   = r_yd;
        opv[OP_T0]   = r_t0;
        opv[OP_K1]   = 64'(signed'(i_cfg.k1));
        opv[OP_K2]   = 64'(signed'(i_cfg.k2));
        opv[OP_K3]   = 64'(signed'(i_cfg.k3));
        opv[OP_P1]   = 64'(signed'(i_cfg.tan[31:0]));
        opv[OP_P2]   = 64'(signed'(i_cfg.tan[63:32]));
        opv[OP_FX]   = {32'b0, i_cfg.focal[31:0]};
        opv[OP_FY]   = {32'b0, i_cfg.focal[63:32]};
        opv[OP_CX]   = {20'b0, i_cfg.pp[31:0], 12'b0};
        opv[OP_CY]   = {20'b0, i_cfg.pp[63:32], 12'b0};
        opv[OP_ONE]  = 64'sd1 <<< FRAC;
    end

    logic signed [63:0] opa, opb;
    assign opa = opv[i_cmd.uop.a];
    assign opb = opv[i_cmd.uop.b];

    // product scaling and saturation
    logic [127:0]       shifted;
    logic [63:0]        mres;
    logic signed [63:0] mval;
    always_comb begin
        shifted = r_sh16 ? (r_acc >> 16) : (r_acc >> FRAC);
        mres    = (shifted[127:62] != '0) ? 64'(LIMIT) : {2'b0, shifted[61:0]};
        mval    = r_neg ? -$signed(mres) : $signed(mres);
    end

    logic               wr_en;
    t_opnd              wr_dst;
    logic signed [63:0] wr_val;
    always_comb begin
        wr_en  = 1'b0;
        wr_dst = i_cmd.uop.dst;
        wr_val = sat_add(opa, opb);
        if (i_cmd.op_issue && i_cmd.uop.kind == UOP_ADD) begin
            wr_en = 1'b1;
        end else if (i_cmd.mul_wb) begin
            wr_en  = 1'b1;
            wr_dst = r_dst;
            wr_val = mval;
        end
    end

    // pixel bounds and round half up
    logic [16:0]        dim_w, dim_h;
    logic signed [63:0] lim_w, lim_h;
    logic               ok_u, ok_v;
    logic [63:0]        ru, rv;
    always_comb begin
        dim_w = (17'(i_cfg.img[15:0]) > DIM_CAP) ? DIM_CAP : 17'(i_cfg.img[15:0]);
        dim_h = (17'(i_cfg.img[31:16]) > DIM_CAP) ? DIM_CAP : 17'(i_cfg.img[31:16]);
        lim_w = $signed(64'(dim_w - 17'd1) << FRAC);
        lim_h = $signed(64'(dim_h - 17'd1) << FRAC);
        ok_u  = (dim_w != '0) && !r_xd[63] && (r_xd <= lim_w);
        ok_v  = (dim_h != '0) && !r_yd[63] && (r_yd <= lim_h);
        ru    = 64'(r_xd) + (64'd1 << (FRAC - 1));
        rv    = 64'(r_yd) + (64'd1 << (FRAC - 1));
    end

    logic [PIXEL_BITS-1:0] pu, pv;
    assign pu = ru[FRAC +: PIXEL_BITS];
    assign pv = rv[FRAC +: PIXEL_BITS];

    assign o_sts.pix_ok  = ok_u && ok_v;
    assign o_sts.top     = r_top;
    assign o_sts.pending = r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (i_cmd.pend_load) begin
            r_pending <= 1'b1;
        end else if (i_cmd.emit) begin
            r_pending <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= i_x;
            r_y     <= i_y;
            r_z     <= i_z;
            r_top   <= i_top;
            r_label <= i_label;
        end
        if (i_cmd.div_init) begin
            r_ux <= ux;
            r_uy <= uy;
            r_ud <= r_z[30:0];
            r_sx <= r_x[31];
            r_sy <= r_y[31];
            r_rx <= 31'(ux >> 3);
            r_ry <= 31'(uy >> 3);
            r_qx <= '0;
            r_qy <= '0;
        end
        if (i_cmd.div_step) begin
            if (tx_t >= {1'b0, r_ud}) begin
                r_rx <= 31'(tx_t - {1'b0, r_ud});
                r_qx <= {r_qx[29:0], 1'b1};
            end else begin
                r_rx <= tx_t[30:0];
                r_qx <= {r_qx[29:0], 1'b0};
            end
            if (ty_t >= {1'b0, r_ud}) begin
                r_ry <= 31'(ty_t - {1'b0, r_ud});
                r_qy <= {r_qy[29:0], 1'b1};
            end else begin
                r_ry <= ty_t[30:0];
                r_qy <= {r_qy[29:0], 1'b0};
            end
        end
        if (i_cmd.op_issue && i_cmd.uop.kind == UOP_MUL) begin
            r_ua   <= opa[63] ? 64'(-opa) : 64'(opa);
            r_ub   <= opb[63] ? 64'(-opb) : 64'(opb);
            r_neg  <= opa[63] ^ opb[63];
            r_sh16 <= i_cmd.uop.sh16;
            r_dst  <= i_cmd.uop.dst;
        end
        // partial products a0b0, a1b0, a0b1, a1b1; each is registered, then accumulated in the next step
        if (i_cmd.mul_step) begin
            r_prod <= (i_cmd.cnt[0] ? r_ua[63:32] : r_ua[31:0])
                      * (i_cmd.cnt[1] ? r_ub[63:32] : r_ub[31:0]);
            r_pshf <= 2'(i_cmd.cnt[0]) + 2'(i_cmd.cnt[1]);
            if (i_cmd.cnt == '0) begin
                r_acc <= '0;
            end else begin
                r_acc <= r_acc + ({64'b0, r_prod} << {r_pshf, 5'b0});
            end
        end
        if (wr_en) begin
            case (wr_dst)
                OP_TXX:  r_txx  <= wr_val;
                OP_TYY:  r_tyy  <= wr_val;
                OP_TXY:  r_txy  <= wr_val;
                OP_R2:   r_r2   <= wr_val;
                OP_R4:   r_r4   <= wr_val;
                OP_R6:   r_r6   <= wr_val;
                OP_DIST: r_dist <= wr_val;
                OP_XD:   r_xd   <= wr_val;
                OP_YD:   r_yd   <= wr_val;
                OP_T0:   r_t0   <= wr_val;
                default: ;
            endcase
        end
        if (i_cmd.pend_load) begin
            r_pu <= pu;
            r_pv <= pv;
        end
        if (i_cmd.emit) begin
            r_olabel <= r_label;
            r_obu    <= PIXOUT_W'(r_pu);
            r_obv    <= PIXOUT_W'(r_pv);
            r_otu    <= PIXOUT_W'(pu);
            r_otv    <= PIXOUT_W'(pv);
        end
    end

    assign o_label = r_olabel;
    assign o_bu    = r_obu;
    assign o_bv    = r_obv;
    assign o_tu    = r_otu;
    assign o_tv    = r_otv;

endmodule

### rtl/camera_point_projection_pairing.sv
// ----------------------------------------------------------------------------
// camera_point_projection_pairing: pinhole projection with lens distortion
// Projects camera-frame points to pixels and pairs bottom/top points.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_point   in   valid/ready   point_x, point_y, point_z, is_top, label
//  o_pair    out  valid/ready   pair_label, bottom_u, bottom_v, top_u, top_v
//  i_cfg_*   in   write enable  index 0..7, 64-bit data
//
//  One point at a time: accept, check, 31-step divider, 16 multiplies of
//  the shared 32x32 multiplier, 16 saturating adds and the pixel check,
//  then a pair when a top point meets a pending bottom. A depth or angle
//  reject ends at the check.
//  Synchronous active-low reset clears the sequencer, the pending flag and the configuration registers.
//  A held result stalls the next point until o_pair is taken.
// ----------------------------------------------------------------------------
module camera_point_projection_pairing import cpp_pkg::*; #(
    parameter int PIXEL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpp_point_if.sink   i_point,
    cpp_pair_if.source  o_pair,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    localparam logic [2:0] REG_DEPTH = 3'd0;
    localparam logic [2:0] REG_FOCAL = 3'd1;
    localparam logic [2:0] REG_PP    = 3'd2;
    localparam logic [2:0] REG_IMG   = 3'd3;
    localparam logic [2:0] REG_K1    = 3'd4;
    localparam logic [2:0] REG_K2    = 3'd5;
    localparam logic [2:0] REG_K3    = 3'd6;
    localparam logic [2:0] REG_TAN   = 3'd7;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic in_ready, out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEPTH: r_cfg.depth <= i_cfg_data;
                REG_FOCAL: r_cfg.focal <= i_cfg_data;
                REG_PP:    r_cfg.pp    <= i_cfg_data;
                REG_IMG:   r_cfg.img   <= i_cfg_data[31:0];
                REG_K1:    r_cfg.k1    <= i_cfg_data[31:0];
                REG_K2:    r_cfg.k2    <= i_cfg_data[31:0];
                REG_K3:    r_cfg.k3    <= i_cfg_data[31:0];
                REG_TAN:   r_cfg.tan   <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    cpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_point.valid),
        .i_out_ready (o_pair.ready),
        .i_sts       (sts),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    cpp_dpath #(.PIXEL_BITS(PIXEL_BITS)) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_cfg   (r_cfg),
        .i_x     (i_point.point_x),
        .i_y     (i_point.point_y),
        .i_z     (i_point.point_z),
        .i_top   (i_point.is_top),
        .i_label (i_point.label),
        .o_sts   (sts),
        .o_label (o_pair.pair_label),
        .o_bu    (o_pair.bottom_u),
        .o_bv    (o_pair.bottom_v),
        .o_tu    (o_pair.top_u),
        .o_tv    (o_pair.top_v)
    );

    assign i_point.ready = in_ready;
    assign o_pair.valid  = out_valid;

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is held");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && o_pair.ready) |=> !sts.pending)
        else $error("pending bottom survived a delivered pair");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_point.valid && in_ready) |=> !in_ready)
        else $error("second point taken while busy");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: camera point projection pairing
// Drives points through the valid/ready point channel under several register
// settings, predicts each pixel pair in a scoreboard class, and checks every
// pair taken from the output channel field by field.
// ----------------------------------------------------------------------------
module testbench;
    import cpp_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 300;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               top;
        logic [15:0]        label;
    } t_point;

    typedef struct {
        logic [15:0] label;
        logic [15:0] bu;
        logic [15:0] bv;
        logic [15:0] tu;
        logic [15:0] tv;
    } t_pixel_pair;

    class pair_scoreboard;
        logic [63:0]  regs [8];
        bit           bottom_held;
        logic [15:0]  held_u;
        logic [15:0]  held_v;
        t_pixel_pair  pairs_due [$];
        int           errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            bottom_held = 0;
            errors = 0;
        endfunction

        function void write_reg(int idx, logic [63:0] d);
            regs[idx] = (idx >= 3 && idx <= 6) ? {32'b0, d[31:0]} : d;
        endfunction

        function longint clamp_sum(longint a, longint b);
            logic signed [64:0] s;
            s = 65'(a) + 65'(b);
            if (s > 65'(LIMIT)) return LIMIT;
            if (s < -65'(LIMIT)) return -LIMIT;
            return longint'(s[63:0]);
        endfunction

        // scaled product, truncated toward zero, clamped to the Q.28 bound
        function longint scaled_mul(longint a, longint b, int sh);
            bit [63:0]  ua, ub;
            bit [127:0] p;
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            p = ({64'b0, ua} * {64'b0, ub}) >> sh;
            if (p > 128'(LIMIT)) p = 128'(LIMIT);
            return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
        endfunction

        function bit ratio_q28(longint n, longint d, output longint q);
            bit [63:0] un;
            un = (n < 0) ? -n : n;
            q = 0;
            if (un >= (d << 3)) return 0;
            q = longint'((un << FRAC) / d);
            if (n < 0) q = -q;
            return 1;
        endfunction

        function bit round_pixel(longint w, longint dim, output logic [15:0] pix);
            longint rounded;
            pix = '0;
            if (dim > 65536) dim = 65536;
            if (dim == 0 || w < 0) return 0;
            if (w > ((dim - 1) <<< FRAC)) return 0;
            rounded = (w + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
            pix = rounded[15:0];
            return 1;
        endfunction

        function bit project(t_point p, output logic [15:0] pu, output logic [15:0] pv);
            longint zmin, zmax, z, k1, k2, k3, p1, p2;
            longint tx, ty, txx, tyy, txy, r2, r4, r6, dcoef, xd, yd, t, u, v;
            pu = '0;
            pv = '0;
            zmin = longint'(regs[0][31:0]);
            zmax = longint'(regs[0][63:32]);
            k1 = longint'($signed(regs[4][31:0]));
            k2 = longint'($signed(regs[5][31:0]));
            k3 = longint'($signed(regs[6][31:0]));
            p1 = longint'($signed(regs[7][31:0]));
            p2 = longint'($signed(regs[7][63:32]));
            z = longint'(p.z);
            if (z < zmin || z > zmax || z <= 0) return 0;
            if (!ratio_q28(longint'(p.x), z, tx)) return 0;
            if (!ratio_q28(longint'(p.y), z, ty)) return 0;
            txx = scaled_mul(tx, tx, FRAC);
            tyy = scaled_mul(ty, ty, FRAC);
            txy = scaled_mul(tx, ty, FRAC);
            r2 = clamp_sum(txx, tyy);
            r4 = scaled_mul(r2, r2, FRAC);
            r6 = scaled_mul(r4, r2, FRAC);
            dcoef = clamp_sum(64'sd1 <<< FRAC, scaled_mul(k1, r2, FRAC));
            dcoef = clamp_sum(dcoef, scaled_mul(k2, r4, FRAC));
            dcoef = clamp_sum(dcoef, scaled_mul(k3, r6, FRAC));
            t = scaled_mul(p1, txy, FRAC);
            xd = clamp_sum(scaled_mul(tx, dcoef, FRAC), clamp_sum(t, t));
            xd = clamp_sum(xd, scaled_mul(p2, clamp_sum(r2, clamp_sum(txx, txx)), FRAC));
            t = scaled_mul(p2, txy, FRAC);
            yd = clamp_sum(scaled_mul(ty, dcoef, FRAC), clamp_sum(t, t));
            yd = clamp_sum(yd, scaled_mul(p1, clamp_sum(r2, clamp_sum(tyy, tyy)), FRAC));
            u = clamp_sum(scaled_mul(xd, longint'(regs[1][31:0]), 16),
                          longint'(regs[2][31:0]) <<< (FRAC - 16));
            v = clamp_sum(scaled_mul(yd, longint'(regs[1][63:32]), 16),
                          longint'(regs[2][63:32]) <<< (FRAC - 16));
            if (!round_pixel(u, longint'(regs[3][15:0]), pu)) return 0;
            if (!round_pixel(v, longint'(regs[3][31:16]), pv)) return 0;
            return 1;
        endfunction

        function void note_point(t_point p);
            logic [15:0] pu, pv;
            t_pixel_pair e;
            if (!project(p, pu, pv)) return;
            if (!p.top) begin
                bottom_held = 1;
                held_u = pu;
                held_v = pv;
            end else if (bottom_held) begin
                bottom_held = 0;
                e.label = p.label;
                e.bu = held_u;
                e.bv = held_v;
                e.tu = pu;
                e.tv = pv;
                pairs_due.push_back(e);
            end
        endfunction

        function void check_pair(t_pixel_pair a);
            t_pixel_pair e;
            if (pairs_due.size() == 0) begin
                $error("unexpected pair: label %0d", a.label);
                errors++;
                return;
            end
            e = pairs_due.pop_front();
            if (a.label !== e.label) begin
                $error("pair_label: expected %0d, got %0d", e.label, a.label);
                errors++;
            end
            if (a.bu !== e.bu) begin
                $error("bottom_u: expected %0d, got %0d", e.bu, a.bu);
                errors++;
            end
            if (a.bv !== e.bv) begin
                $error("bottom_v: expected %0d, got %0d", e.bv, a.bv);
                errors++;
            end
            if (a.tu !== e.tu) begin
                $error("top_u: expected %0d, got %0d", e.tu, a.tu);
                errors++;
            end
            if (a.tv !== e.tv) begin
                $error("top_v: expected %0d, got %0d", e.tv, a.tv);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    cpp_point_if point_ch ();
    cpp_pair_if  pair_ch ();

    camera_point_projection_pairing uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_point    (point_ch.sink),
        .o_pair     (pair_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    pair_scoreboard sb = new();
    int  points_taken = 0;
    bit  pair_taken = 0;
    bit  steady = 0;        // no idling on either side while set
    int  sink_stall = 0;
    int  idle_cycles = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // monitors sample at the rising edge, before any update of the block
    always @(posedge i_clk) begin
        t_point p;
        t_pixel_pair a;
        if (i_rst_n && point_ch.valid && point_ch.ready) begin
            p.x = point_ch.point_x;
            p.y = point_ch.point_y;
            p.z = point_ch.point_z;
            p.top = point_ch.is_top;
            p.label = point_ch.label;
            sb.note_point(p);
            points_taken++;
        end
        if (i_rst_n && pair_ch.valid && pair_ch.ready) begin
            a.label = pair_ch.pair_label;
            a.bu = pair_ch.bottom_u;
            a.bv = pair_ch.bottom_v;
            a.tu = pair_ch.top_u;
            a.tv = pair_ch.top_v;
            sb.check_pair(a);
            pair_taken = 1;
        end
    end

    // watchdog: cycles with no transaction on any port
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((point_ch.valid && point_ch.ready) || (pair_ch.valid && pair_ch.ready)
                || i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // result side: draw a stall after each pair taken, spend it on the next pair
    always @(negedge i_clk) begin
        if (pair_taken) begin
            sink_stall = steady ? 0 : $urandom_range(0, 12);
            pair_taken = 0;
        end
        if (sink_stall > 0) begin
            pair_ch.ready = 0;
            if (pair_ch.valid) sink_stall--;
        end else begin
            pair_ch.ready = 1;
        end
    end

    task automatic send_point(t_point p);
        int gap;
        int n;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            point_ch.valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        point_ch.point_x = p.x;
        point_ch.point_y = p.y;
        point_ch.point_z = p.z;
        point_ch.is_top = p.top;
        point_ch.label = p.label;
        point_ch.valid = 1;
        n = points_taken;
        do @(negedge i_clk); while (points_taken == n);
    endtask

    // drain outstanding pairs, then let a point with no result finish
    task automatic settle();
        point_ch.valid = 0;
        while (sb.pairs_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_cfg(int idx, logic [63:0] d);
        i_cfg_we = 1;
        i_cfg_idx = idx[2:0];
        i_cfg_data = d;
        sb.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic load_settings(logic [63:0] s [8]);
        settle();
        for (int i = 0; i < 8; i++) write_cfg(i, s[i]);
    endtask

    function automatic t_point mk_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic top, logic [15:0] label);
        t_point p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.top = top;
        p.label = label;
        return p;
    endfunction

    // point within a view cone of plausible depth
    function automatic t_point scene_point(logic top);
        int unsigned z, lim;
        z = $urandom_range(32'h0000_8000, 32'h0040_0000);
        lim = (z / 10) * 9;
        return mk_point(32'($urandom_range(0, 2 * lim)) - lim,
                        32'($urandom_range(0, 2 * lim)) - lim,
                        z, top, 16'($urandom()));
    endfunction

    function automatic t_point noise_point();
        logic [31:0] z;
        z = ($urandom_range(0, 1)) ? $urandom() : $urandom_range(0, 32'h0100_0000);
        return mk_point($urandom(), $urandom(), z, 1'($urandom()), 16'($urandom()));
    endfunction

    task automatic random_points(int count);
        int done;
        int r;
        done = 0;
        while (done < count) begin
            if (done % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (r < 6) begin
                // well-formed column: bottom then top
                send_point(scene_point(1'b0));
                send_point(scene_point(1'b1));
                done += 2;
            end else if (r < 8) begin
                send_point(scene_point(1'($urandom())));
                done++;
            end else begin
                send_point(noise_point());
                done++;
            end
        end
        steady = 0;
    endtask

    initial begin
        logic [63:0] typical [8];
        logic [63:0] edge_cfg [8];
        logic [63:0] wild [8];
        logic [63:0] no_width [8];
        logic [63:0] tilted [8];

        typical = '{{32'h0040_0000, 32'h0000_8000}, {32'd500 << 16, 32'd500 << 16},
                    {32'd240 << 16, 32'd320 << 16}, 64'h01E0_0280,
                    64'(-32'sd53687091), 64'd13421773, 64'd0,
                    {32'hFFFB_E7ED, 32'h0004_1893}};
        edge_cfg = '{{32'hFFFF_FFFF, 32'h0}, {64{1'b1}}, {64{1'b1}}, 64'hFFFF_FFFF,
                     64'h7FFF_FFFF, 64'h8000_0000, 64'h7FFF_FFFF,
                     {32'h8000_0000, 32'h7FFF_FFFF}};
        wild = '{{32'hFFFF_FFFF, 32'h0}, {32'd1000 << 16, 32'd1000 << 16},
                 {32'd32768 << 16, 32'd32768 << 16}, 64'hFFFF_FFFF,
                 64'h8000_0000, 64'h7FFF_FFFF, 64'h8000_0000,
                 {32'h7FFF_FFFF, 32'h8000_0000}};
        no_width = typical;
        no_width[3] = 64'h01E0_0000;
        tilted = typical;
        tilted[1] = {32'd300 << 16, 32'd700 << 16};
        tilted[3] = 64'h0001_0001;
        tilted[6] = 64'd4000000;
        tilted[7] = {32'h0100_0000, 32'hFF00_0000};

        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        point_ch.valid = 0;
        point_ch.point_x = '0;
        point_ch.point_y = '0;
        point_ch.point_z = '0;
        point_ch.is_top = 0;
        point_ch.label = '0;
        pair_ch.ready = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // registers at reset: every point is rejected
        random_points(40);

        load_settings(typical);
        // top with nothing pending, then a centered column
        send_point(mk_point(0, 0, 32'h0001_0000, 1'b1, 16'h0000));
        send_point(mk_point(0, 0, 32'h0001_0000, 1'b0, 16'h0001));
        send_point(mk_point(32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000, 1'b1, 16'hFFFF));
        // bottom at the nearest depth, rejects that keep it pending, then a top that pairs with it
        send_point(mk_point(0, 0, 32'h0000_8000, 1'b0, 16'h1234));
        send_point(mk_point(0, 0, 32'h0000_7FFF, 1'b0, 16'h1234));
        send_point(mk_point(0, 0, 32'h0040_0001, 1'b0, 16'h1234));
        send_point(mk_point(0, 0, 32'h0000_0000, 1'b1, 16'h1234));
        send_point(mk_point(0, 0, 32'h8000_0000, 1'b1, 16'h1234));
        send_point(mk_point(32'h7FFF_FFFF, 0, 32'h0010_0000, 1'b1, 16'h5555));
        send_point(mk_point(0, 32'h8000_0000, 32'h0010_0000, 1'b1, 16'hAAAA));
        send_point(mk_point(32'h0080_0000, 0, 32'h0010_0000, 1'b1, 16'h0F0F));
        send_point(mk_point(32'h0007_FFFF, 0, 32'h0001_0000, 1'b1, 16'hF0F0));
        send_point(mk_point(0, 0, 32'h0020_0000, 1'b1, 16'h00FF));
        // bottom while pending replaces the held pixel
        send_point(mk_point(32'h0000_8000, 0, 32'h0001_0000, 1'b0, 16'h0));
        send_point(mk_point(0, 32'h0000_8000, 32'h0001_0000, 1'b0, 16'h0));
        send_point(mk_point(32'hFFFF_8000, 32'hFFFF_8000, 32'h0001_0000, 1'b1, 16'h8001));
        send_point(mk_point(32'hFFFE_0000, 32'h0, 32'h0001_0000, 1'b1, 16'h7FFE));
        random_points(420);

        load_settings(edge_cfg);
        send_point(mk_point(0, 0, 32'h7FFF_FFFF, 1'b0, 16'h0));
        send_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'hFFFF));
        random_points(100);

        load_settings(wild);
        random_points(380);

        load_settings(no_width);
        random_points(60);

        load_settings(tilted);
        random_points(300);

        settle();
        if (sb.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

### camera_point_projection_pairing.f
rtl/cpp_pkg.sv
rtl/cpp_point_if.sv
rtl/cpp_pair_if.sv
rtl/cpp_ctrl.sv
rtl/cpp_dpath.sv
rtl/camera_point_projection_pairing.sv
test/testbench.sv
